// ----- rtl/core/dfs_pkg.sv -----
// Shared types and constants for the depth-first search path finder.
// No dependencies; imported by dfs_path_finder.
package dfs_pkg;

  localparam int NODE_W   = 5;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 8;

  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic {
    ACT_ADD   = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

endpackage

// ----- rtl/core/dfs_path_finder.sv -----
// Top level of the depth-first search path finder: graph storage, search engine and output.
// Depends on dfs_pkg.

// The block takes add-edge and query transfers on the slave stream. An add-edge transfer
// is accepted in IDLE, then appended to node_a's list in ADD_A and to node_b's list in
// ADD_B. A query clears the visited marks in its accept cycle. It then spends a FETCH and
// a CHECK state on each neighbor-list entry it examines and a FETCH and a POP state on
// each backtrack, because every neighbor lookup and every stack pop waits on a
// synchronous memory read. Each path node then leaves through OUT_RD and OUT_WR, and the
// final node or the empty answer through OUT_TOP or EMPTY, when the master side is ready.
// The neighbor lists and the saved search frames live in two memories that need no
// clearing after reset; the node degrees and visited marks are flops.
module dfs_path_finder #(
  parameter int NODES      = 26,
  parameter int MAX_DEGREE = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // Fields from bit 0: node_a[4:0], node_b[9:5], zero padding.
  input  logic [dfs_pkg::S_DATA_W-1:0]  s_tdata,
  // Fields from bit 0: action.
  input  logic [0:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // Fields from bit 0: found[0], path_node[5:1], zero padding.
  output logic [dfs_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                          m_tlast
);
  import dfs_pkg::*;

  localparam int NW        = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int IW        = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int DW        = $clog2(MAX_DEGREE + 1);
  localparam int SW        = $clog2(NODES + 1);
  localparam int NBR_DEPTH = NODES << IW;
  localparam logic [NODE_W:0] NODES_L = (NODE_W + 1)'(NODES);
  localparam logic [DW-1:0]   MAXD_L  = DW'(MAX_DEGREE);
  localparam logic [SW-1:0]   NODES_S = SW'(NODES);

  typedef enum logic [3:0] {
    IDLE, ADD_A, ADD_B, FETCH, CHECK, POP, OUT_RD, OUT_WR, OUT_TOP, EMPTY
  } state_t;

  typedef struct packed {
    node_t         node;
    logic [DW-1:0] cur;
  } frame_t;

  state_t              state;
  node_t               node_a;
  node_t               node_b;
  node_t               top_node;
  logic [DW-1:0]       top_cur;
  logic [SW-1:0]       depth;
  logic [SW-1:0]       out_idx;
  logic [NODES-1:0]    visited;
  logic [DW-1:0]       degree [NODES];

  node_t               nbr_mem [NBR_DEPTH];
  node_t               nbr_rdata;
  frame_t              stk_mem [NODES];
  frame_t              stk_rdata;

  node_t               in_a;
  node_t               in_b;
  logic                in_ok;
  node_t               sel_node;
  node_t               sel_other;
  logic [DW-1:0]       sel_deg;
  logic                nbr_we;
  logic                nbr_re;
  logic [NW+IW-1:0]    nbr_waddr;
  logic [NW+IW-1:0]    nbr_raddr;
  logic                nb_ok;
  logic                push;
  logic                stk_we;
  logic                stk_re;
  logic [NW-1:0]       stk_waddr;
  logic [NW-1:0]       stk_raddr;
  logic [SW-1:0]       depth_m1;
  logic [SW-1:0]       depth_m2;
  logic [SW-1:0]       out_idx_p1;
  logic                out_free;
  logic                out_load;

  assign s_tready = (state == IDLE);
  assign in_a     = s_tdata[NODE_W-1:0];
  assign in_b     = s_tdata[2*NODE_W-1:NODE_W];
  assign in_ok    = ({1'b0, in_a} < NODES_L) && ({1'b0, in_b} < NODES_L);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (state)
      ADD_A: begin
        sel_node  = node_a;
        sel_other = node_b;
      end
      ADD_B: begin
        sel_node  = node_b;
        sel_other = node_a;
      end
      default: begin
        sel_node  = top_node;
        sel_other = node_b;
      end
    endcase
    sel_deg    = degree[sel_node[NW-1:0]];
    nbr_we     = ((state == ADD_A) || (state == ADD_B)) && (sel_deg < MAXD_L);
    nbr_waddr  = {sel_node[NW-1:0], sel_deg[IW-1:0]};
    nbr_re     = (state == FETCH) && (top_cur < sel_deg);
    nbr_raddr  = {top_node[NW-1:0], top_cur[IW-1:0]};
    depth_m1   = depth - SW'(1);
    depth_m2   = depth - SW'(2);
    out_idx_p1 = out_idx + SW'(1);
    nb_ok      = {1'b0, nbr_rdata} < NODES_L;
    push       = nb_ok && !visited[nbr_rdata[NW-1:0]] && (depth < NODES_S);
    stk_we     = (state == CHECK) && push;
    stk_waddr  = depth_m1[NW-1:0];
    stk_re     = ((state == FETCH) && !nbr_re && (depth > SW'(1))) || (state == OUT_RD);
    stk_raddr  = (state == OUT_RD) ? out_idx[NW-1:0] : depth_m2[NW-1:0];
    out_load   = (state inside {OUT_WR, OUT_TOP, EMPTY}) && out_free;
  end

  always_ff @(posedge clk) begin
    if (nbr_we) begin
      nbr_mem[nbr_waddr] <= sel_other;
    end
    if (nbr_re) begin
      nbr_rdata <= nbr_mem[nbr_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= '{node: top_node, cur: top_cur};
    end
    if (stk_re) begin
      stk_rdata <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        degree[i] <= '0;
      end
    end else if (nbr_we) begin
      degree[sel_node[NW-1:0]] <= sel_deg + DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      visited  <= '0;
      depth    <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tlast  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            node_a <= in_a;
            node_b <= in_b;
            if (action_t'(s_tuser[0]) == ACT_ADD) begin
              state <= in_ok ? ADD_A : IDLE;
            end else if (!in_ok) begin
              state <= EMPTY;
            end else begin
              visited  <= NODES'(1) << in_a[NW-1:0];
              top_node <= in_a;
              top_cur  <= '0;
              depth    <= SW'(1);
              state    <= (in_a == in_b) ? OUT_TOP : FETCH;
            end
          end
        end
        ADD_A: begin
          state <= ADD_B;
        end
        ADD_B: begin
          state <= IDLE;
        end
        FETCH: begin
          if (nbr_re) begin
            top_cur <= top_cur + DW'(1);
            state   <= CHECK;
          end else begin
            depth <= depth_m1;
            state <= (depth > SW'(1)) ? POP : EMPTY;
          end
        end
        CHECK: begin
          if (push) begin
            visited[nbr_rdata[NW-1:0]] <= 1'b1;
            top_node                   <= nbr_rdata;
            top_cur                    <= '0;
            depth                      <= depth + SW'(1);
            out_idx                    <= '0;
            state                      <= (nbr_rdata == node_b) ? OUT_RD : FETCH;
          end else begin
            state <= FETCH;
          end
        end
        POP: begin
          top_node <= stk_rdata.node;
          top_cur  <= stk_rdata.cur;
          state    <= FETCH;
        end
        OUT_RD: begin
          state <= OUT_WR;
        end
        OUT_WR: begin
          if (out_free) begin
            m_tdata  <= {2'b00, stk_rdata.node, 1'b1};
            m_tlast  <= 1'b0;
            out_idx  <= out_idx_p1;
            state    <= (out_idx_p1 == depth_m1) ? OUT_TOP : OUT_RD;
          end
        end
        OUT_TOP: begin
          if (out_free) begin
            m_tdata  <= {2'b00, top_node, 1'b1};
            m_tlast  <= 1'b1;
            state    <= IDLE;
          end
        end
        EMPTY: begin
          if (out_free) begin
            m_tdata  <= '0;
            m_tlast  <= 1'b1;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= NODES_S)
    else $error("search depth exceeds the node count");

  a_fetch_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == FETCH) |-> (depth != '0))
    else $error("neighbor fetch with an empty stack");

  a_top_visited: assert property (@(posedge clk) disable iff (rst)
    (state == FETCH) |-> visited[top_node[NW-1:0]])
    else $error("top of stack is not marked visited");

  a_empty_answer: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tlast && (m_tdata[5:1] == '0)))
    else $error("empty answer is not a single zero result");

  a_add_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == ADD_A) |=> ((state == ADD_B) && !$rose(m_tvalid)))
    else $error("add-edge sequence produced a result");
`endif

endmodule

// ----- bench/dfs_path_finder_check.sv -----
// Checker for the depth-first search path finder: watches both streams, keeps its own
// copy of the graph, predicts every path and compares each result transfer in order.
// Depends on dfs_pkg; instantiated by dfs_path_finder_test.
module dfs_path_finder_check #(
  parameter int NODES      = 26,
  parameter int MAX_DEGREE = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  // Fields from bit 0: node_a[4:0], node_b[9:5], zero padding.
  input  logic [dfs_pkg::S_DATA_W-1:0]  s_tdata,
  // Fields from bit 0: action.
  input  logic [0:0]                    s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  // Fields from bit 0: found[0], path_node[5:1], zero padding.
  input  logic [dfs_pkg::M_DATA_W-1:0]  m_tdata,
  input  logic                          m_tlast,
  output int                            errors,
  output int                            pending,
  output int                            results,
  output int                            empties
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            found;
    dfs_pkg::node_t  node;
    logic            last;
  } hop_t;

  hop_t            route_q[$];
  dfs_pkg::node_t  nbr_list [NODES*MAX_DEGREE];
  int unsigned     degree [NODES];
  bit              visited [NODES];
  dfs_pkg::node_t  trail [NODES];
  int unsigned     cursor [NODES];
  int unsigned     depth;
  int              n_err, n_res, n_empty;

  function automatic void add_neighbor(int unsigned u, int unsigned v);
    if (degree[u] < MAX_DEGREE) begin
      nbr_list[u*MAX_DEGREE + degree[u]] = v[dfs_pkg::NODE_W-1:0];
      degree[u]++;
    end
  endfunction

  function automatic bit find_route(int unsigned s, int unsigned t);
    int unsigned top, c, nb;
    foreach (visited[i]) visited[i] = 1'b0;
    visited[s] = 1'b1;
    trail[0]   = s[dfs_pkg::NODE_W-1:0];
    cursor[0]  = 0;
    depth      = 1;
    if (s == t) return 1'b1;
    while (depth > 0) begin
      top = trail[depth-1];
      c   = cursor[depth-1];
      if (c < degree[top]) begin
        nb = nbr_list[top*MAX_DEGREE + c];
        cursor[depth-1] = c + 1;
        if (!visited[nb] && depth < NODES) begin
          visited[nb]   = 1'b1;
          trail[depth]  = nb[dfs_pkg::NODE_W-1:0];
          cursor[depth] = 0;
          depth++;
          if (nb == t) return 1'b1;
        end
      end else begin
        depth--;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    int unsigned a, b;
    hop_t want, got;
    if (rst) begin
      foreach (degree[i]) degree[i] = 0;
      route_q.delete();
      n_err   = 0;
      n_res   = 0;
      n_empty = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[0], m_tdata[5:1], m_tlast};
        n_res++;
        if (route_q.size() == 0) begin
          $error("Unexpected result transfer: found %0d, path_node %0d, last_of_run %0d",
                 got.found, got.node, got.last);
          n_err++;
        end else begin
          want = route_q.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            n_err++;
          end
          if (got.node !== want.node) begin
            $error("path_node: expected %0d, actual %0d", want.node, got.node);
            n_err++;
          end
          if (got.last !== want.last) begin
            $error("last_of_run: expected %0d, actual %0d", want.last, got.last);
            n_err++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        a = s_tdata[4:0];
        b = s_tdata[9:5];
        if (s_tuser == dfs_pkg::ACT_ADD) begin
          if (a < NODES && b < NODES) begin
            add_neighbor(a, b);
            add_neighbor(b, a);
          end
        end else if (a >= NODES || b >= NODES || !find_route(a, b)) begin
          want    = '{1'b0, '0, 1'b1};
          route_q = {route_q, want};
          n_empty++;
        end else begin
          for (int i = 0; i < depth; i++) begin
            want    = '{1'b1, trail[i], (i == depth - 1)};
            route_q = {route_q, want};
          end
        end
      end
    end
    errors  <= n_err;
    pending <= route_q.size();
    results <= n_res;
    empties <= n_empty;
  end

endmodule

// ----- bench/dfs_path_finder_test.sv -----
// Top of the path finder testbench: clock, reset, directed and random edge and query
// transfers, random back-pressure and the verdict.
// Depends on dfs_pkg, dfs_path_finder and dfs_path_finder_check.
module dfs_path_finder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dfs_pkg::*;

  localparam int NODES      = 26;
  localparam int MAX_DEGREE = 32;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata;
  logic [0:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 m_tlast;

  int errors, pending, results, empties;
  int n_edges, n_queries;
  bit hold_done;

  dfs_path_finder #(
    .NODES      (NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  dfs_path_finder_check #(
    .NODES      (NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) i_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending),
    .results  (results),
    .empties  (empties)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic node_t pick_node(int unsigned span);
    if ($urandom_range(0, 99) < 6) return node_t'($urandom_range(NODES, 31));
    if ($urandom_range(0, 99) < 15) return node_t'($urandom_range(0, 2));
    return node_t'($urandom_range(0, span));
  endfunction

  task automatic send(action_t act, node_t a, node_t b);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {{(S_DATA_W-2*NODE_W){1'b0}}, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (act == ACT_ADD) n_edges++;
    else n_queries++;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int    burst, gap;
    m_tready  = 1'b0;
    hold_done = 1'b0;
    wait (rst === 1'b0);
    forever begin
      // One long hold-off so that the block fills up and stalls its input.
      if (!hold_done && results >= 30) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      m_tready <= 1'b1;
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      repeat (burst) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned span;
    node_t       a, b;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = ACT_ADD;
    n_edges   = 0;
    n_queries = 0;
    rst       = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty graph, start equal to target, and ends out of range.
    send(ACT_QUERY, 5'd0, 5'd1);
    send(ACT_QUERY, 5'd0, 5'd0);
    send(ACT_QUERY, 5'd31, 5'd0);
    send(ACT_ADD, 5'd0, 5'd26);
    send(ACT_ADD, 5'd0, 5'd1);
    send(ACT_ADD, 5'd1, 5'd2);
    send(ACT_QUERY, 5'd2, 5'd0);
    // Self loops fill the list of X, so X cannot take W as a neighbor.
    repeat (16) send(ACT_ADD, 5'd23, 5'd23);
    send(ACT_ADD, 5'd23, 5'd22);
    send(ACT_QUERY, 5'd22, 5'd23);
    send(ACT_QUERY, 5'd23, 5'd22);

    for (int i = 0; i < 450; i++) begin
      span = (3 + i / 12 > NODES - 1) ? NODES - 1 : 3 + i / 12;
      a = pick_node(span);
      b = ($urandom_range(0, 19) == 0) ? a : pick_node(span);
      if ($urandom_range(0, 99) < ((i < 60) ? 70 : 50)) send(ACT_ADD, a, b);
      else send(ACT_QUERY, a, b);
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Covered %0d edge and %0d query transfers, %0d results, %0d empty answers.",
             n_edges, n_queries, results, empties);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/dfs_pkg.sv
rtl/core/dfs_path_finder.sv
bench/dfs_path_finder_check.sv
bench/dfs_path_finder_test.sv
